// ===== design/bicdf_pkg.sv =====
package bicdf_pkg;

  // Default and upper bound for the trial count
  localparam int MAX_TRIALS_DEF = 32;

  // Fixed-point constants
  localparam logic [16:0] Q16_ONE = 17'h1_0000;
  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
  localparam logic [31:0] Q32_MAX = 32'hFFFF_FFFF;

  // Widest binomial coefficient for up to 32 trials: C(32,16) < 2^30
  localparam int COEF_W = 30;

  // Register interface
  localparam int CFG_DATA_W = 17;
  localparam logic REG_SUCCESS_PROB = 1'b0;
  localparam logic REG_TRIAL_COUNT  = 1'b1;
  localparam logic [16:0] SUCCESS_PROB_RST = 17'd32768;
  localparam logic [5:0]  TRIAL_COUNT_RST  = 6'd1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_QPOW,
    ST_PROD,
    ST_SPLIT,
    ST_SAT,
    ST_COMMIT,
    ST_SRCH_START,
    ST_SRCH,
    ST_DONE
  } state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic init;       // start a table build
    logic qpow;       // one power step of q plus one Pascal row pass
    logic prod;       // p^k * q^(n-k)
    logic split;      // coefficient times product, two halves
    logic sat;        // join halves, saturate the term
    logic commit;     // accumulate, write table entry, advance k
    logic last_term;  // entry being committed is cdf[n]
    logic out_load;   // load the result register
  } cmd_t;

endpackage

// ===== design/bicdf_dp.sv =====
module bicdf_dp import bicdf_pkg::*; #(
  parameter int MaxTrials = MAX_TRIALS_DEF,
  localparam int CntW = $clog2(MaxTrials + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [15:0]           sample_i,
  input  logic                  last_i,
  input  cmd_t                  cmd_i,
  input  logic [CntW-1:0]       k_i,
  input  logic [CntW-1:0]       rd_addr_i,
  output logic [CntW-1:0]       n_o,
  output logic                  gt_o,
  output logic [5:0]            successes_o,
  output logic                  last_o
);

  logic [16:0] prob_q;
  logic [5:0]  trials_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_q   <= SUCCESS_PROB_RST;
      trials_q <= TRIAL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SUCCESS_PROB: prob_q   <= cfg_data_i;
        REG_TRIAL_COUNT:  trials_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Clamped p, q and n
  logic [16:0] p;
  logic [16:0] q;
  assign p   = (prob_q > Q16_ONE) ? Q16_ONE : prob_q;
  assign q   = Q16_ONE - p;
  assign n_o = (trials_q > 6'(MaxTrials)) ? CntW'(MaxTrials) : CntW'(trials_q);

  logic [32:0] pacc_q;
  logic [32:0] qacc_q;
  logic [32:0] stack_q [MaxTrials+1];
  logic [COEF_W-1:0] row_q [MaxTrials+1];
  logic [32:0] prod_q;
  logic [45:0] lo_q;
  logic [45:0] hi_q;
  logic        ovf_q;
  logic [31:0] term_q;
  logic [31:0] sum_q;
  logic [15:0] sample_q;
  logic        last_q;

  // Shared power step: (acc * f + 2^15) >> 16
  logic [32:0] step_in;
  logic [16:0] step_f;
  logic [49:0] step_full;
  logic [49:0] step_rnd;
  logic [32:0] step_out;
  assign step_in   = cmd_i.qpow ? qacc_q : pacc_q;
  assign step_f    = cmd_i.qpow ? q : p;
  assign step_full = step_in * step_f;
  assign step_rnd  = step_full + 50'd32768;
  assign step_out  = step_rnd[48:16];

  // Product of the two powers, exact when either side is one
  logic [63:0] pq_full;
  logic [63:0] pq_rnd;
  logic [32:0] prod_d;
  assign pq_full = pacc_q[31:0] * stack_q[0][31:0];
  assign pq_rnd  = pq_full + 64'h8000_0000;
  always_comb begin
    if (pacc_q == Q32_ONE) begin
      prod_d = stack_q[0];
    end else if (stack_q[0] == Q32_ONE) begin
      prod_d = {1'b0, pacc_q[31:0]};
    end else begin
      prod_d = {1'b0, pq_rnd[63:32]};
    end
  end

  // Term assembly and saturation
  logic [61:0] term_full;
  logic [31:0] term_d;
  assign term_full = {hi_q, 16'h0} + 62'(lo_q);
  assign term_d    = (ovf_q || (term_full[61:32] != '0)) ? Q32_MAX : term_full[31:0];

  // Saturating running sum
  logic [32:0] sum_full;
  logic [31:0] sum_d;
  assign sum_full = {1'b0, sum_q} + {1'b0, term_q};
  assign sum_d    = sum_full[32] ? Q32_MAX : sum_full[31:0];

  // Build registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      pacc_q <= Q32_ONE;
      qacc_q <= Q32_ONE;
      sum_q  <= '0;
      stack_q[0] <= Q32_ONE;
      row_q[0] <= COEF_W'(1);
      for (int i = 1; i <= MaxTrials; i++) row_q[i] <= '0;
    end
    if (cmd_i.qpow) begin
      qacc_q     <= step_out;
      stack_q[0] <= step_out;
      for (int i = 1; i <= MaxTrials; i++) begin
        stack_q[i] <= stack_q[i-1];
        row_q[i]   <= row_q[i] + row_q[i-1];
      end
    end
    if (cmd_i.prod) prod_q <= prod_d;
    if (cmd_i.split) begin
      lo_q  <= row_q[0] * prod_q[15:0];
      hi_q  <= row_q[0] * prod_q[31:16];
      ovf_q <= prod_q[32];
    end
    if (cmd_i.sat) term_q <= term_d;
    if (cmd_i.commit) begin
      sum_q  <= sum_d;
      pacc_q <= step_out;
      for (int i = 0; i < MaxTrials; i++) begin
        stack_q[i] <= stack_q[i+1];
        row_q[i]   <= row_q[i+1];
      end
      row_q[MaxTrials] <= '0;
    end
  end

  // Cumulative table memory
  logic [31:0] cdf_mem [MaxTrials+1];
  logic [31:0] rdata_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) cdf_mem[k_i] <= cmd_i.last_term ? Q32_MAX : sum_d;
    rdata_q <= cdf_mem[rd_addr_i];
  end

  // Item capture and search compare
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
      last_q   <= last_i;
    end
  end
  assign gt_o = {sample_q, 16'h0} > rdata_q;

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      successes_o <= 6'(k_i);
      last_o      <= last_q;
    end
  end

endmodule

// ===== design/bicdf_ctrl.sv =====
module bicdf_ctrl import bicdf_pkg::*; #(
  parameter int MaxTrials = MAX_TRIALS_DEF,
  localparam int CntW = $clog2(MaxTrials + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic [CntW-1:0] n_i,
  input  logic            gt_i,
  output cmd_t            cmd_o,
  output logic [CntW-1:0] k_o,
  output logic [CntW-1:0] rd_addr_o
);

  state_e state_q, state_d;
  logic [CntW-1:0] k_q, k_d;
  logic ready_q, ready_d;
  logic valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      ready_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ready_q <= ready_d;
      valid_q <= valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    ready_d   = ready_q;
    valid_d   = valid_q && !out_ready_i;
    cmd_o     = '0;
    rd_addr_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          k_d = '0;
          state_d = ready_q ? ST_SRCH_START : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        k_d = '0;
        state_d = ST_QPOW;
      end
      ST_QPOW: begin
        if (k_q != n_i) begin
          cmd_o.qpow = 1'b1;
          k_d = k_q + CntW'(1);
        end else begin
          k_d = '0;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.last_term = (k_q == n_i);
        if (k_q == n_i) begin
          ready_d = 1'b1;
          k_d = '0;
          state_d = ST_SRCH_START;
        end else begin
          k_d = k_q + CntW'(1);
          state_d = ST_PROD;
        end
      end
      ST_SRCH_START: begin
        rd_addr_o = '0;
        state_d = ST_SRCH;
      end
      ST_SRCH: begin
        // read data holds cdf[k]; next address fetched speculatively
        rd_addr_o = k_q + CntW'(1);
        if ((k_q < n_i) && gt_i) begin
          k_d = k_q + CntW'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // any register write invalidates the table
    if (cfg_we_i) ready_d = 1'b0;
  end

  assign out_valid_o = valid_q;
  assign k_o = k_q;

endmodule

// ===== design/binomial_inverse_cdf_sampler_core.sv =====
// Binomial(n,p) sampler by inverse transform. Each input item carries a Q0.16
// uniform sample; the result item is the smallest k with sample <= cdf[k].
// The first item after reset or after any register write first builds the
// cumulative table: power and Pascal-row steps, then the product, split,
// saturate and commit states for each table entry. With a valid table an
// item goes straight to the linear search, which reads one table entry per
// cycle from the table memory and stops at the result k. One item is in
// flight at a time; the result register lets the next item be accepted
// while a result still waits downstream.
module binomial_inverse_cdf_sampler_core import bicdf_pkg::*; #(
  parameter int MaxTrials = MAX_TRIALS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] uniform_sample
  input  logic                  s_axis_tlast,   // last_request
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [5:0] successes, [7:6] zero
  output logic                  m_axis_tlast    // last_result
);

  localparam int CntW = $clog2(MaxTrials + 1);

  cmd_t            cmd;
  logic [CntW-1:0] k;
  logic [CntW-1:0] rd_addr;
  logic [CntW-1:0] n;
  logic            gt;
  logic [5:0]      successes;

  bicdf_ctrl #(.MaxTrials(MaxTrials)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .n_i         (n),
    .gt_i        (gt),
    .cmd_o       (cmd),
    .k_o         (k),
    .rd_addr_o   (rd_addr)
  );

  bicdf_dp #(.MaxTrials(MaxTrials)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .k_i         (k),
    .rd_addr_i   (rd_addr),
    .n_o         (n),
    .gt_o        (gt),
    .successes_o (successes),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, successes};

`ifndef SYNTHESIS
  // Result never exceeds the trial bound
  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5:0] <= 6'(MaxTrials)))
    else $error("result above trial bound");

  // One item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // A new result only appears after the block was busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result produced from idle");
`endif

endmodule
